### rtl/iptp_pkg.sv
// ----------------------------------------------------------------------------
// iptp_pkg: shared types and constants for the address text parser
// Character classes, parser phases and the item passed from front to back.
// ----------------------------------------------------------------------------
package iptp_pkg;

   localparam int unsigned QueueDepth = 4;

   // parser phases
   localparam logic [2:0] PH_RUN   = 3'd0;
   localparam logic [2:0] PH_FAIL  = 3'd1;
   localparam logic [2:0] PH_END   = 3'd2;
   localparam logic [2:0] PH_SLASH = 3'd3;
   localparam logic [2:0] PH_OTHER = 3'd4;

   // prefix reader phases
   localparam logic [1:0] PX_WAIT = 2'd0;
   localparam logic [1:0] PX_WS   = 2'd1;
   localparam logic [1:0] PX_DIG  = 2'd2;
   localparam logic [1:0] PX_DONE = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // item from front to back: a character with its end marker
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } item_type;

   function automatic logic [2:0] stop_kind(input logic [7:0] c);
      if (c == CH_NUL) begin
         return PH_END;
      end else if (c == CH_SLASH) begin
         return PH_SLASH;
      end
      return PH_OTHER;
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

endpackage

### rtl/iptp_front.sv
// ----------------------------------------------------------------------------
// iptp_front: input stage with item queue
// Accepts characters, folds embedded NUL, and queues items for the back end.
// ----------------------------------------------------------------------------
module iptp_front
   import iptp_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_ch,
   input  logic       in_last,
   output logic       q_valid,
   input  logic       q_ready,
   output item_type   q_item
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type         mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             ended_ff, ended_in;
   logic             push, pop;
   item_type         push_item;

   assign in_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = mem_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   // classify: after a NUL every character reads as NUL until the end
   always_comb begin
      push_item.ch   = ended_ff ? CH_NUL : in_ch;
      push_item.last = in_last;
      ended_in = ended_ff;
      if (push) begin
         ended_in = in_last ? 1'b0 : (ended_ff || (in_ch == CH_NUL));
      end
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      if (push) wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      if (pop)  rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         cnt_ff   <= '0;
         ended_ff <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         cnt_ff   <= cnt_in;
         ended_ff <= ended_in;
      end
   end

endmodule

### rtl/iptp_back.sv
// ----------------------------------------------------------------------------
// iptp_back: parser engine
// Runs the IPv4 and IPv6 parsers and the prefix reader, builds the result.
// A last item is processed as its own character followed by three NUL flushes.
// ----------------------------------------------------------------------------
module iptp_back
   import iptp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_ok,
   output logic        out_v6,
   output logic [63:0] out_hi,
   output logic [63:0] out_lo,
   output logic [6:0]  out_plen
);
   // parser state
   logic [7:0]  v4o_ff [4];
   logic [7:0]  v4o_in [4];
   logic [8:0]  v4a_ff, v4a_in;
   logic [2:0]  v4c_ff, v4c_in;
   logic [2:0]  v4p_ff, v4p_in;
   logic [15:0] v6g_ff [8];
   logic [15:0] v6g_in [8];
   logic [3:0]  v6b_ff, v6b_in, v6f_ff, v6f_in;
   logic [16:0] v6a_ff, v6a_in;
   logic [2:0]  v6p_ff, v6p_in;
   logic        dc_ff, dc_in, skip_ff, skip_in, st_ff, st_in;
   logic [7:0]  la0_ff, la0_in, la1_ff, la1_in;
   logic [1:0]  lc_ff, lc_in;
   logic [1:0]  scd_ff, scd_in;
   logic [7:0]  pa_ff, pa_in;
   logic [1:0]  pp_ff, pp_in;
   logic        pn_ff, pn_in;
   logic [1:0]  fl_ff, fl_in;      // flush NULs still to feed
   logic        busy_ff, busy_in;  // flushing
   logic        fin;               // last flush this cycle

   // result register
   logic        ov_ff;
   logic        ook_ff, ov6_ff;
   logic [63:0] ohi_ff, olo_ff;
   logic [6:0]  opl_ff;

   logic        take, fire;
   logic [7:0]  c;

   assign take  = q_valid && q_ready;
   assign q_ready = !busy_ff && (!ov_ff || out_ready);
   assign fire  = take || busy_ff;
   assign c     = busy_ff ? CH_NUL : q_item.ch;
   assign fin   = busy_ff && (fl_ff == 2'd1);

   assign out_valid = ov_ff;
   assign out_ok    = ook_ff;
   assign out_v6    = ov6_ff;
   assign out_hi    = ohi_ff;
   assign out_lo    = olo_ff;
   assign out_plen  = opl_ff;

   // one step of the parsers
   always_comb begin
      logic [7:0]  p0, p1;
      logic [4:0]  h;
      logic        hv, dg;
      logic [20:0] t6;
      logic [12:0] t4;
      logic [3:0]  tot;
      logic [11:0] pv;
      logic        ws;
      for (int i = 0; i < 4; i++) v4o_in[i] = v4o_ff[i];
      for (int i = 0; i < 8; i++) v6g_in[i] = v6g_ff[i];
      v4a_in = v4a_ff; v4c_in = v4c_ff; v4p_in = v4p_ff;
      v6b_in = v6b_ff; v6f_in = v6f_ff; v6a_in = v6a_ff; v6p_in = v6p_ff;
      dc_in = dc_ff; skip_in = skip_ff; st_in = st_ff;
      la0_in = la0_ff; la1_in = la1_ff; lc_in = lc_ff; scd_in = scd_ff;
      pa_in = pa_ff; pp_in = pp_ff; pn_in = pn_ff;
      fl_in = fl_ff; busy_in = busy_ff;
      p0 = la0_ff; p1 = la1_ff;
      h = '0; hv = 1'b0; dg = 1'b0; t6 = '0; t4 = '0; tot = '0; pv = '0; ws = 1'b0;

      if (fire) begin
         // classify and prefix reader
         if (c == CH_COLON) scd_in[0] = 1'b1;
         if (c == CH_DOT)   scd_in[1] = 1'b1;
         dg = is_dec(c);
         ws = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
         pv = {4'd0, pa_ff} * 12'd10 + {8'd0, c[3:0]};
         unique case (pp_ff)
            PX_WAIT: if (c == CH_SLASH) pp_in = PX_WS;
            PX_WS: begin
               if (ws) begin
                  pp_in = PX_WS;
               end else if (c == 8'h2B) begin
                  pp_in = PX_DIG;
               end else if (c == 8'h2D) begin
                  pn_in = 1'b1; pp_in = PX_DIG;
               end else if (!dg) begin
                  pp_in = PX_DONE;
               end else begin
                  pp_in = PX_DIG;
                  pa_in = (pv > 12'd255) ? 8'd255 : pv[7:0];
               end
            end
            PX_DIG: begin
               if (dg) pa_in = (pv > 12'd255) ? 8'd255 : pv[7:0];
               else    pp_in = PX_DONE;
            end
            default: pp_in = PX_DONE;
         endcase

         if (lc_ff < 2'd2) begin
            if (lc_ff == 2'd0) la0_in = c; else la1_in = c;
            lc_in = lc_ff + 2'd1;
         end else begin
            // IPv6 step on p0 with lookahead p1, c
            if (v6p_ff == PH_RUN) begin
               if (skip_ff) begin
                  skip_in = 1'b0;
               end else begin
                  hv = 1'b1;
                  if (is_dec(p0)) h = {1'b0, p0[3:0]};
                  else if (p0 >= 8'h41 && p0 <= 8'h46) h = 5'(p0 - 8'h37);
                  else if (p0 >= 8'h61 && p0 <= 8'h66) h = 5'(p0 - 8'h57);
                  else hv = 1'b0;
                  if (hv) begin
                     t6 = {v6a_ff, 4'd0} + {16'd0, h};
                     v6a_in = (t6 > 21'd65536) ? 17'd65536 : t6[16:0];
                  end else if (v6a_ff > 17'd65535) begin
                     v6p_in = PH_FAIL;
                  end else begin
                     tot = v6b_ff + v6f_ff;
                     if (!st_ff) begin
                        v6g_in[tot[2:0]] = v6a_ff[15:0];
                        if (dc_ff) v6f_in = v6f_ff + 4'd1;
                        else       v6b_in = v6b_ff + 4'd1;
                        tot = tot + 4'd1;
                     end
                     if (p0 != CH_COLON || tot == 4'd8) begin
                        v6p_in = stop_kind(p0);
                     end else if (p1 == CH_COLON) begin
                        if (dc_ff || c == CH_COLON) begin
                           v6p_in = PH_OTHER;
                        end else begin
                           dc_in = 1'b1; skip_in = 1'b1; v6a_in = '0;
                        end
                     end else if (st_ff) begin
                        v6p_in = PH_FAIL;
                     end else begin
                        v6a_in = '0;
                     end
                  end
               end
            end
            // IPv4 step on p0 with lookahead p1
            if (v4p_ff == PH_RUN) begin
               if (is_dec(p0)) begin
                  t4 = {1'b0, v4a_ff, 3'd0} + {3'd0, v4a_ff, 1'b0} + {9'd0, p0[3:0]};
                  v4a_in = (t4 > 13'd256) ? 9'd256 : t4[8:0];
               end else if (v4a_ff > 9'd255) begin
                  v4p_in = PH_FAIL;
               end else begin
                  v4o_in[v4c_ff[1:0]] = v4a_ff[7:0];
                  v4c_in = v4c_ff + 3'd1;
                  if (p0 != CH_DOT || p1 == CH_DOT) begin
                     v4p_in = stop_kind(p0);
                  end else begin
                     v4a_in = '0;
                     if (v4c_ff >= 3'd3) v4p_in = stop_kind(p1);
                  end
               end
            end
            st_in  = 1'b0;
            la0_in = la1_ff;
            la1_in = c;
         end

         // flush sequencing
         if (take && q_item.last) begin
            busy_in = 1'b1; fl_in = 2'd3;
         end else if (busy_ff) begin
            fl_in = fl_ff - 2'd1;
            if (fl_ff == 2'd1) busy_in = 1'b0;
         end
      end
   end

   // final result from the state after the last flush
   logic        r_ok, r_v6;
   logic [63:0] r_hi, r_lo;
   logic [6:0]  r_pl, r_mx;
   logic [2:0]  r_ph;
   logic [3:0]  r_tot;
   always_comb begin
      logic [3:0] src;
      logic [15:0] g;
      r_v6  = scd_in[0];
      r_hi  = '0; r_lo = '0; r_pl = '0;
      r_tot = v6b_in + v6f_in;
      src = '0; g = '0;
      if (r_v6) begin
         r_ph = v6p_in; r_mx = 7'd64;
         r_ok = (r_ph == PH_END || r_ph == PH_SLASH) &&
                (dc_in ? (r_tot < 4'd8) : (r_tot == 4'd8));
         if (r_ok) begin
            for (int k = 0; k < 8; k++) begin
               g = '0;
               src = v6b_in + 4'(k) - (4'd8 - v6f_in);
               if (4'(k) < v6b_in) g = v6g_in[k];
               else if (4'(k) >= 4'd8 - v6f_in) g = v6g_in[src[2:0]];
               if (k < 4) r_hi[63-16*k -: 16] = g;
               else       r_lo[63-16*(k-4) -: 16] = g;
            end
         end
      end else begin
         r_ph = v4p_in; r_mx = 7'd32;
         r_ok = scd_in[1] && (r_ph == PH_END || r_ph == PH_SLASH);
         if (r_ok) begin
            for (int k = 0; k < 4; k++) r_hi[63-8*k -: 8] = v4o_in[k];
         end
      end
      if (r_ok) begin
         r_pl = r_mx;
         if (r_ph == PH_SLASH && !pn_in && pa_in >= 8'd1 && pa_in <= {1'b0, r_mx})
            r_pl = pa_in[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         ook_ff <= r_ok; ov6_ff <= r_v6;
         ohi_ff <= r_hi; olo_ff <= r_lo; opl_ff <= r_pl;
      end
   end

   // state registers; clear everything after the result is captured
   always_ff @(posedge clock) begin
      if (reset || fin) begin
         for (int i = 0; i < 4; i++) v4o_ff[i] <= '0;
         for (int i = 0; i < 8; i++) v6g_ff[i] <= '0;
         v4a_ff <= '0; v4c_ff <= '0; v4p_ff <= PH_RUN;
         v6b_ff <= '0; v6f_ff <= '0; v6a_ff <= '0; v6p_ff <= PH_RUN;
         dc_ff <= 1'b0; skip_ff <= 1'b0; st_ff <= 1'b1;
         la0_ff <= '0; la1_ff <= '0; lc_ff <= '0; scd_ff <= '0;
         pa_ff <= '0; pp_ff <= PX_WAIT; pn_ff <= 1'b0;
         fl_ff <= '0; busy_ff <= 1'b0;
      end else begin
         for (int i = 0; i < 4; i++) v4o_ff[i] <= v4o_in[i];
         for (int i = 0; i < 8; i++) v6g_ff[i] <= v6g_in[i];
         v4a_ff <= v4a_in; v4c_ff <= v4c_in; v4p_ff <= v4p_in;
         v6b_ff <= v6b_in; v6f_ff <= v6f_in; v6a_ff <= v6a_in; v6p_ff <= v6p_in;
         dc_ff <= dc_in; skip_ff <= skip_in; st_ff <= st_in;
         la0_ff <= la0_in; la1_ff <= la1_in; lc_ff <= lc_in; scd_ff <= scd_in;
         pa_ff <= pa_in; pp_ff <= pp_in; pn_ff <= pn_in;
         fl_ff <= fl_in; busy_ff <= busy_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (fin) begin
         ov_ff <= 1'b1;
      end else if (out_ready) begin
         ov_ff <= 1'b0;
      end
   end

endmodule

### rtl/ip_address_text_parser.sv
// ----------------------------------------------------------------------------
// ip_address_text_parser: IPv4 / IPv6 address text parser
// The result is registered after the last character passes through the queue
// and the engine runs its own step and three flush steps.
// Throughput: one character per cycle unless the engine is flushing or a
// result waits; a last character holds the engine while the lookahead is NUL-flushed.
// Reset: synchronous, active high; clears queue, parser state and result valid.
// ----------------------------------------------------------------------------
module ip_address_text_parser
   import iptp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] ch
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata    // [0] valid_res [1] is_ipv6 [65:2] addr_high
                                     // [129:66] addr_low [136:130] prefix_len
);
   logic        q_valid, q_ready;
   item_type    q_item;
   logic        ok, v6;
   logic [63:0] hi, lo;
   logic [6:0]  pl;

   iptp_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_ch(req_tdata), .in_last(req_tlast),
      .q_valid, .q_ready, .q_item
   );

   iptp_back u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_item,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_ok(ok), .out_v6(v6), .out_hi(hi), .out_lo(lo), .out_plen(pl)
   );

   assign rsp_tdata = {7'd0, pl, lo, hi, v6, ok};

endmodule

### sim/ip_address_text_parser_tb.sv
// ----------------------------------------------------------------------------
// ip_address_text_parser_tb: self-checking bench for the address text parser
// Streams address strings one character per item, predicts the parse result
// of each string in a local model and checks every result item field by
// field. Sender bursts and receiver stalls vary, with one long hold-off.
// ----------------------------------------------------------------------------
module ip_address_text_parser_tb;
   import iptp_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int LongHold      = 400;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   typedef struct {
      logic        ok;
      logic        is_v6;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [6:0]  plen;
   } parse_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] ch
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;   // [0] valid_res [1] is_ipv6 [65:2] addr_high
                              // [129:66] addr_low [136:130] prefix_len

   char_item_type    pending_chars[$];
   parse_result_type expected_parses[$];
   int               errors;
   int               rsp_count;
   int               idle_cycles;
   bit               req_taken;

   ip_address_text_parser dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // ------------------------------------------------------------------
   // parser model state
   // ------------------------------------------------------------------
   logic [7:0] m_octets[4];
   int         m_v4_acc, m_v4_cnt;
   logic [2:0] m_v4_ph;
   logic [15:0] m_groups[8];
   int         m_bc, m_ac, m_v6_acc;
   logic [2:0] m_v6_ph;
   bit         m_dc, m_skip, m_at_start, m_ended, m_neg;
   logic [7:0] m_look[2];
   int         m_look_cnt;
   logic [1:0] m_seen;
   int         m_px_acc;
   logic [1:0] m_px_ph;

   function automatic void model_clear();
      for (int i = 0; i < 4; i++) m_octets[i] = '0;
      for (int i = 0; i < 8; i++) m_groups[i] = '0;
      m_look[0] = '0; m_look[1] = '0;
      m_v4_acc = 0; m_v4_cnt = 0; m_v4_ph = PH_RUN;
      m_bc = 0; m_ac = 0; m_v6_acc = 0; m_v6_ph = PH_RUN;
      m_dc = 0; m_skip = 0; m_at_start = 1; m_look_cnt = 0; m_seen = '0;
      m_px_acc = 0; m_px_ph = PX_WAIT; m_neg = 0; m_ended = 0;
   endfunction

   function automatic logic [2:0] end_kind(logic [7:0] c);
      if (c == CH_NUL) return PH_END;
      if (c == CH_SLASH) return PH_SLASH;
      return PH_OTHER;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   // colon-hex parser, one character with two lookahead characters
   function automatic void v6_advance(logic [7:0] c, logic [7:0] n1, logic [7:0] n2);
      int h;
      if (m_v6_ph != PH_RUN) return;
      if (m_skip) begin
         m_skip = 0;
         return;
      end
      h = hex_digit(c);
      if (h >= 0) begin
         m_v6_acc = m_v6_acc * 16 + h;
         if (m_v6_acc > 65536) m_v6_acc = 65536;
         return;
      end
      if (m_v6_acc > 65535) begin
         m_v6_ph = PH_FAIL;
         return;
      end
      if (!m_at_start) begin
         m_groups[(m_bc + m_ac) & 7] = m_v6_acc[15:0];
         if (m_dc) m_ac++;
         else m_bc++;
      end
      if (c != CH_COLON || m_bc + m_ac == 8) begin
         m_v6_ph = end_kind(c);
         return;
      end
      if (n1 == CH_COLON) begin
         if (m_dc || n2 == CH_COLON) begin
            m_v6_ph = PH_OTHER;
            return;
         end
         m_dc = 1;
         m_skip = 1;
      end else if (m_at_start) begin
         m_v6_ph = PH_FAIL;
         return;
      end
      m_v6_acc = 0;
   endfunction

   // dotted-decimal parser
   function automatic void v4_advance(logic [7:0] c, logic [7:0] n1);
      if (m_v4_ph != PH_RUN) return;
      if (c >= "0" && c <= "9") begin
         m_v4_acc = m_v4_acc * 10 + (c - "0");
         if (m_v4_acc > 256) m_v4_acc = 256;
         return;
      end
      if (m_v4_acc > 255) begin
         m_v4_ph = PH_FAIL;
         return;
      end
      m_octets[m_v4_cnt & 3] = m_v4_acc[7:0];
      m_v4_cnt++;
      if (c != CH_DOT || n1 == CH_DOT) begin
         m_v4_ph = end_kind(c);
         return;
      end
      m_v4_acc = 0;
      if (m_v4_cnt >= 4) m_v4_ph = end_kind(n1);
   endfunction

   function automatic void shift_in(logic [7:0] c);
      if (m_look_cnt < 2) begin
         m_look[m_look_cnt] = c;
         m_look_cnt++;
         return;
      end
      v6_advance(m_look[0], m_look[1], c);
      v4_advance(m_look[0], m_look[1]);
      m_at_start = 0;
      m_look[0] = m_look[1];
      m_look[1] = c;
   endfunction

   // prefix reader: atoi-like value after the slash
   function automatic void prefix_advance(logic [7:0] c);
      bit dig;
      dig = (c >= "0" && c <= "9");
      case (m_px_ph)
         PX_WAIT: begin
            if (c == CH_SLASH) m_px_ph = PX_WS;
         end
         PX_WS: begin
            if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            end else if (c == "+") begin
               m_px_ph = PX_DIG;
            end else if (c == "-") begin
               m_neg = 1;
               m_px_ph = PX_DIG;
            end else if (!dig) begin
               m_px_ph = PX_DONE;
            end else begin
               m_px_ph = PX_DIG;
               m_px_acc = m_px_acc * 10 + (c - "0");
            end
         end
         PX_DIG: begin
            if (dig) begin
               m_px_acc = m_px_acc * 10 + (c - "0");
               if (m_px_acc > 255) m_px_acc = 255;
            end else begin
               m_px_ph = PX_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   // advance one character; returns 1 with the parse result on the last one
   function automatic bit parse_char(logic [7:0] c_in, logic last,
                                     output parse_result_type r);
      logic [7:0] c;
      logic [2:0] ph;
      int         maxp, total;
      logic [63:0] g;
      c = m_ended ? CH_NUL : c_in;
      r = '{default: '0};
      if (c == CH_NUL) m_ended = 1;
      if (c == CH_COLON) m_seen[0] = 1'b1;
      if (c == CH_DOT) m_seen[1] = 1'b1;
      prefix_advance(c);
      shift_in(c);
      if (!last) return 0;
      shift_in(CH_NUL); shift_in(CH_NUL); shift_in(CH_NUL);
      r.is_v6 = m_seen[0];
      if (m_seen[0]) begin
         ph = m_v6_ph; maxp = 64;
         total = m_bc + m_ac;
         r.ok = (ph == PH_END || ph == PH_SLASH) && (m_dc ? total < 8 : total == 8);
         if (r.ok) begin
            for (int k = 0; k < 8; k++) begin
               g = '0;
               if (k < m_bc) g = m_groups[k];
               else if (k >= 8 - m_ac) g = m_groups[(m_bc + k - (8 - m_ac)) & 7];
               if (k < 4) r.hi |= g << (48 - 16 * k);
               else r.lo |= g << (48 - 16 * (k - 4));
            end
         end
      end else begin
         ph = m_v4_ph; maxp = 32;
         r.ok = m_seen[1] && (ph == PH_END || ph == PH_SLASH);
         if (r.ok) begin
            for (int k = 0; k < 4; k++) r.hi |= 64'(m_octets[k]) << (56 - 8 * k);
         end
      end
      if (r.ok) begin
         r.plen = maxp[6:0];
         if (ph == PH_SLASH && !m_neg && m_px_acc >= 1 && m_px_acc <= maxp)
            r.plen = m_px_acc[6:0];
      end
      model_clear();
      return 1;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic void queue_char(logic [7:0] c, logic last);
      char_item_type it;
      it.ch = c; it.last = last;
      pending_chars.push_back(it);
   endfunction

   // queue a string, optionally with one character replaced by a random byte
   function automatic void queue_text(string s, bit mutate);
      int pos;
      logic [7:0] c;
      pos = mutate ? $urandom_range(s.len() - 1) : -1;
      for (int i = 0; i < s.len(); i++) begin
         c = (i == pos) ? 8'($urandom_range(255)) : s[i];
         queue_char(c, i == s.len() - 1);
      end
   endfunction

   function automatic string rand_prefix();
      case ($urandom_range(5))
         0: return $sformatf("/%0d", $urandom_range(1, 64));
         1: return $sformatf("/%0d", $urandom_range(300));
         2: return $sformatf("/ -%0d", $urandom_range(40));
         3: return $sformatf("/\t+%0dx", $urandom_range(70));
         default: return "";
      endcase
   endfunction

   function automatic string rand_v4();
      string s;
      int n;
      s = "";
      n = ($urandom_range(7) == 0) ? $urandom_range(1, 5) : 4;
      for (int i = 0; i < n; i++) begin
         if (i > 0) begin
            if ($urandom_range(15) == 0) s = {s, ".."};
            else s = {s, "."};
         end
         if ($urandom_range(9) != 0)
            s = {s, $sformatf("%0d", ($urandom_range(7) == 0) ? $urandom_range(999)
                                                               : $urandom_range(255))};
      end
      if ($urandom_range(7) == 0) s = {s, "."};
      return {s, rand_prefix()};
   endfunction

   function automatic string rand_v6();
      string hexch, s;
      int n, dc_at, len;
      hexch = "0123456789abcdefABCDEF";
      s = "";
      n = ($urandom_range(5) == 0) ? $urandom_range(1, 9) : 8;
      dc_at = ($urandom_range(2) == 0) ? $urandom_range(n) : -1;
      if (dc_at >= 0 && n == 8) n = $urandom_range(7);
      for (int i = 0; i < n; i++) begin
         if (i == dc_at) s = {s, "::"};
         else if (i > 0) s = {s, ":"};
         len = ($urandom_range(9) == 0) ? $urandom_range(6) : $urandom_range(1, 4);
         for (int j = 0; j < len; j++)
            s = {s, string'(hexch[$urandom_range(21)])};
      end
      if (dc_at >= n) s = {s, "::"};
      if (s.len() == 0) s = "::";
      return {s, rand_prefix()};
   endfunction

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin
      int sent;
      string s;
      reset = 1'b1;
      model_clear();
      // directed strings
      queue_text("0.0.0.0", 0);
      queue_text("255.255.255.255/24", 0);
      queue_text("256.1.1.1", 0);
      queue_text("1..2.3", 0);
      queue_text("10.20.30.40.", 0);
      queue_text("1.2.3.4/ -5", 0);
      queue_text("1.2.3.4/33", 0);
      queue_text("::", 0);
      queue_text("::1/128", 0);
      queue_text("1:2:3:4:5:6:7:8", 0);
      queue_text("ffff:FFFF:0:0:0:0:0:ABCD/64", 0);
      queue_text(":1::2", 0);
      queue_text(":::", 0);
      queue_text("1::2::3", 0);
      queue_text("1:2:3:4:5:6:7:8:9", 0);
      queue_text("1:2:3", 0);
      queue_text("10000::1", 0);
      queue_text("fe80::/+10 junk", 0);
      queue_text("abc", 0);
      queue_text("1.2.3.4x", 0);
      queue_char("1", 0); queue_char(".", 0); queue_char("2", 0);
      queue_char(CH_NUL, 0); queue_char(":", 0); queue_char(8'hFF, 1);
      queue_char(8'hFF, 1);
      queue_char(CH_NUL, 1);
      // random strings, mostly well formed, until about 200 characters are queued
      sent = 0;
      while (sent < 200) begin
         case ($urandom_range(9))
            0, 1, 2, 3: s = rand_v4();
            4, 5, 6, 7: s = rand_v6();
            default: begin
               s = "";
               repeat ($urandom_range(1, 6)) s = {s, "x"};
            end
         endcase
         queue_text(s, (s[0] == "x") || ($urandom_range(9) == 0));
         sent += s.len();
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_chars.size() == 0 && !req_tvalid && expected_parses.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_parses.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // driver: bursts with gaps, inputs change on the falling edge
   // ------------------------------------------------------------------
   int burst_left, gap_left;
   char_item_type cur;

   initial begin
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0; rsp_tready = 1'b0;
      errors = 0; rsp_count = 0; idle_cycles = 0; req_taken = 0;
      burst_left = 0; gap_left = 0;
   end

   always @(posedge clock) begin
      parse_result_type r;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         if (parse_char(req_tdata, req_tlast, r)) expected_parses.push_back(r);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
      end else if (req_tvalid && !req_taken) begin
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
         cur = pending_chars.pop_front();
         req_tdata <= cur.ch;
         req_tlast <= cur.last;
         req_tvalid <= 1'b1;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // receiver: changing stall pattern plus one long hold-off
   // ------------------------------------------------------------------
   int stall_mode, mode_left, hold_left, accepted_chars;
   bit long_hold_done;

   initial begin
      stall_mode = 0; mode_left = 0; hold_left = 0; accepted_chars = 0;
      long_hold_done = 0;
   end

   always @(posedge clock) begin
      if (req_taken) accepted_chars++;
   end

   always @(negedge clock) begin
      if (!long_hold_done && accepted_chars > 150) begin
         long_hold_done = 1;
         hold_left = LongHold;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(3);
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(1);
            2: rsp_tready <= ($urandom_range(7) == 0);
            default: rsp_tready <= (mode_left % 5 != 0);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // monitor and watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      parse_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_parses.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item %h", $time, rsp_tdata);
         end else begin
            e = expected_parses.pop_front();
            if (rsp_tdata[0] !== e.ok) begin
               errors++;
               $display("%0t: valid_res exp %b got %b", $time, e.ok, rsp_tdata[0]);
            end
            if (rsp_tdata[1] !== e.is_v6) begin
               errors++;
               $display("%0t: is_ipv6 exp %b got %b", $time, e.is_v6, rsp_tdata[1]);
            end
            if (rsp_tdata[65:2] !== e.hi) begin
               errors++;
               $display("%0t: addr_high exp %h got %h", $time, e.hi, rsp_tdata[65:2]);
            end
            if (rsp_tdata[129:66] !== e.lo) begin
               errors++;
               $display("%0t: addr_low exp %h got %h", $time, e.lo, rsp_tdata[129:66]);
            end
            if (rsp_tdata[136:130] !== e.plen) begin
               errors++;
               $display("%0t: prefix_len exp %0d got %0d", $time, e.plen,
                        rsp_tdata[136:130]);
            end
         end
      end
      if (reset || req_taken || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
